### sv/soqt_pkg.sv
// ----------------------------------------------------------------------------
// soqt_pkg
// shared types and constants for the session owner quota table
// ----------------------------------------------------------------------------
package soqt_pkg;

	localparam int INODE_SLOTS   = 1024;
	localparam int SESSION_SLOTS = 16;
	localparam int IDX_W  = $clog2(INODE_SLOTS);
	localparam int SLOT_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
	localparam logic [31:0] BYTE_CAP_RESET = 32'd16777216;

	localparam logic [2:0] KIND_TAG      = 3'd0;
	localparam logic [2:0] KIND_LOOKUP   = 3'd1;
	localparam logic [2:0] KIND_NEXT     = 3'd2;
	localparam logic [2:0] KIND_CLEAR    = 3'd3;
	localparam logic [2:0] KIND_CHARGE   = 3'd4;
	localparam logic [2:0] KIND_UNCHARGE = 3'd5;
	localparam logic [2:0] KIND_READ     = 3'd6;

	typedef struct packed {
		logic [2:0]  kind;
		logic [10:0] inode_number;
		logic [31:0] session_id;
		logic [10:0] after_inode;
		logic [31:0] byte_amount;
	} req_t;

	typedef struct packed {
		logic [31:0] owner_session;
		logic        is_visible;
		logic [10:0] next_owned_inode;
		logic        charge_status;
		logic [31:0] session_bytes;
	} rsp_t;

endpackage

### sv/soqt_if.sv
// ----------------------------------------------------------------------------
// soqt_if
// valid / ready channel carrying one item
// ----------------------------------------------------------------------------
interface soqt_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/session_owner_quota_table_core.sv
// ----------------------------------------------------------------------------
// session_owner_quota_table_core
// inode owner table plus per-session byte quota accounting
// ----------------------------------------------------------------------------
// One item at a time. Clear and next owned walk the 1024-entry owner
// memory through its single read port, one entry a cycle. After reset the
// owner memory is wiped before the first item is taken. byte_cap may be
// written at any idle time.
module session_owner_quota_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	soqt_if.sink        req,
	soqt_if.source      rsp
);
	import soqt_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0]  state_q;
	logic [31:0] cap_q;
	req_t        req_q;
	logic        start_s1;
	logic        own_start, own_done, slot_done;
	logic        own_idle;
	logic        own_done_q, slot_done_q;
	logic        own_wait_q;
	logic [31:0] owner;
	logic [10:0] next_ino;
	logic        status;
	logic [31:0] bytes;
	rsp_t        rsp_q;
	logic        acc;

	// take an item only when idle, the owner memory is ready and the result
	// register is free
	assign req.ready = state_q == ST_IDLE && own_idle && !rsp.valid;
	assign acc = req.valid && req.ready;
	assign own_start = start_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= BYTE_CAP_RESET;
		else if (cfg_we) cap_q <= cfg_wdata;
	end

	always_ff @(posedge clk) if (acc) req_q <= req.data;

	soqt_owner_scan u_owner (
		.clk, .arst_n, .start(own_start), .req(req_q), .idle(own_idle),
		.done(own_done), .owner, .next_ino
	);

	soqt_slots u_slots (
		.clk, .arst_n, .start(start_s1), .req(req_q),
		.do_clear(own_done && own_wait_q && req_q.kind == KIND_CLEAR),
		.byte_cap(cap_q), .done(slot_done), .status, .bytes
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_s1    <= 1'b0;
			own_done_q  <= 1'b0;
			slot_done_q <= 1'b0;
			own_wait_q  <= 1'b0;
			rsp.valid   <= 1'b0;
		end else begin
			start_s1 <= acc;
			if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
			case (state_q)
				ST_IDLE: if (acc) begin
					state_q     <= ST_BUSY;
					own_done_q  <= 1'b0;
					slot_done_q <= 1'b0;
				end
				ST_BUSY: begin
					if (start_s1) own_wait_q <= 1'b1;
					if (own_done) begin
						own_done_q <= 1'b1;
						own_wait_q <= 1'b0;
					end
					if (slot_done) slot_done_q <= 1'b1;
					if ((own_done_q || own_done) && (slot_done_q || slot_done) &&
						!start_s1) state_q <= ST_OUT;
				end
				ST_OUT: begin
					rsp.valid <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// assemble the result item
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT) begin
			rsp_q.owner_session    <= owner;
			rsp_q.is_visible       <= (req_q.kind == KIND_LOOKUP) &&
				(owner == '0 || (req_q.session_id != '0 && owner == req_q.session_id));
			rsp_q.next_owned_inode <= next_ino;
			rsp_q.charge_status    <= status;
			rsp_q.session_bytes    <= bytes;
		end
	end
	assign rsp.data = rsp_q;

endmodule

### sv/soqt_slots.sv
// ----------------------------------------------------------------------------
// soqt_slots
// session accounting slots with one shared add / compare unit
// ----------------------------------------------------------------------------
module soqt_slots (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  soqt_pkg::req_t         req,
	input  logic                   do_clear,
	input  logic [31:0]            byte_cap,
	output logic                   done,
	output logic                   status,
	output logic [31:0]            bytes
);
	import soqt_pkg::*;

	logic [SESSION_SLOTS-1:0] in_use_q;
	logic [31:0] sess_q [SESSION_SLOTS];
	logic [31:0] cnt_q  [SESSION_SLOTS];

	logic [SESSION_SLOTS-1:0] hit;
	logic any_hit, any_free;
	logic [SLOT_W-1:0] hit_idx, free_idx, idx;
	logic [31:0] cur, room, nxt;
	logic reject;

	// one-hot match and first free slot
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		any_hit  = 1'b0;
		any_free = 1'b0;
		for (int i = SESSION_SLOTS - 1; i >= 0; i--) begin
			hit[i] = in_use_q[i] && (sess_q[i] == req.session_id);
			if (hit[i]) begin
				any_hit = 1'b1;
				hit_idx = SLOT_W'(i);
			end
			if (!in_use_q[i]) begin
				any_free = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
		idx = any_hit ? hit_idx : free_idx;
		cur = any_hit ? cnt_q[hit_idx] : '0;
		room = byte_cap - req.byte_amount;
		reject = (req.byte_amount > byte_cap) || (cur > room);
		if (req.kind == KIND_CHARGE) nxt = cur + req.byte_amount;
		else nxt = (req.byte_amount >= cur) ? '0 : cur - req.byte_amount;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			done     <= 1'b0;
		end else begin
			done <= start;
			if (do_clear && req.session_id != '0)
				in_use_q <= in_use_q & ~hit;
			if (start && req.session_id != '0) begin
				case (req.kind)
					KIND_CHARGE: begin
						if (any_hit || any_free) begin
							in_use_q[idx] <= 1'b1;
							sess_q[idx]   <= req.session_id;
							if (!reject) cnt_q[idx] <= nxt;
							else if (!any_hit) cnt_q[idx] <= '0;
						end
					end
					KIND_UNCHARGE: begin
						if (any_hit) cnt_q[idx] <= nxt;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			status <= (req.kind == KIND_CHARGE) && req.session_id != '0 &&
				(!(any_hit || any_free) || reject);
			bytes <= (req.kind == KIND_READ) ? cur : '0;
		end
	end

endmodule

### sv/soqt_owner_scan.sv
// ----------------------------------------------------------------------------
// soqt_owner_scan
// owner table memory with a one-entry-per-cycle scan sequencer
// ----------------------------------------------------------------------------
module soqt_owner_scan (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  soqt_pkg::req_t  req,
	output logic            idle,
	output logic            done,
	output logic [31:0]     owner,
	output logic [10:0]     next_ino
);
	import soqt_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WIPE  = 3'd1;
	localparam logic [2:0] ST_RD    = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_LOOK  = 3'd4;

	logic [31:0] mem [INODE_SLOTS];
	logic [2:0]  state_q;
	logic [IDX_W:0] ptr_q, rd_ptr_s1;
	logic [31:0] rd_s1;
	logic        rd_v_s1;
	logic        wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [31:0] wr_data;
	logic [2:0]  kind_q;
	logic [31:0] sess_q;
	logic        look_ok_q;
	logic        in_range;

	assign in_range = req.inode_number != '0 && 32'(req.inode_number) <= INODE_SLOTS;

	// no new item while the wipe, a lookup or a scan is running
	assign idle = state_q == ST_IDLE;

	// write port: tag, wipe after reset, clear scan
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ptr_q[IDX_W-1:0];
		wr_data = '0;
		if (state_q == ST_WIPE) wr_en = 1'b1;
		else if (state_q == ST_IDLE && start && req.kind == KIND_TAG && in_range) begin
			wr_en   = 1'b1;
			wr_addr = IDX_W'(req.inode_number - 11'd1);
			wr_data = req.session_id;
		end else if (state_q == ST_SCAN && rd_v_s1 && kind_q == KIND_CLEAR &&
			rd_s1 == sess_q) begin
			wr_en   = 1'b1;
			wr_addr = rd_ptr_s1[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_s1     <= mem[(state_q == ST_IDLE) ? IDX_W'(req.inode_number - 11'd1)
			: ptr_q[IDX_W-1:0]];
		rd_ptr_s1 <= ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_WIPE;
			ptr_q    <= '0;
			done     <= 1'b0;
			rd_v_s1  <= 1'b0;
			kind_q   <= '0;
			sess_q   <= '0;
			look_ok_q <= 1'b0;
			owner    <= '0;
			next_ino <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_WIPE: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == (IDX_W+1)'(INODE_SLOTS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					rd_v_s1 <= 1'b0;
					if (start) begin
						kind_q   <= req.kind;
						sess_q   <= req.session_id;
						owner    <= '0;
						next_ino <= '0;
						if (req.kind == KIND_LOOKUP) begin
							look_ok_q <= in_range;
							state_q   <= ST_LOOK;
						end else if ((req.kind == KIND_NEXT || req.kind == KIND_CLEAR) &&
							req.session_id != '0 &&
							(req.kind == KIND_CLEAR || 32'(req.after_inode) < INODE_SLOTS)) begin
							ptr_q   <= (req.kind == KIND_CLEAR) ? '0
								: (IDX_W+1)'(req.after_inode);
							state_q <= ST_RD;
						end else done <= 1'b1;
					end
				end
				ST_LOOK: begin
					owner   <= look_ok_q ? rd_s1 : '0;
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_RD, ST_SCAN: begin
					state_q <= ST_SCAN;
					if (32'(ptr_q) < INODE_SLOTS) ptr_q <= ptr_q + 1'b1;
					rd_v_s1 <= 32'(ptr_q) < INODE_SLOTS;
					if (state_q == ST_SCAN) begin
						if (kind_q == KIND_NEXT && rd_v_s1 && rd_s1 == sess_q) begin
							next_ino <= 11'(rd_ptr_s1 + 1'b1);
							done     <= 1'b1;
							rd_v_s1  <= 1'b0;
							state_q  <= ST_IDLE;
						end else if (!rd_v_s1) begin
							done    <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
